[hdl/lsbt_pkg.sv]
// ---------------------------------------------------------------------------
// lsbt_pkg
// Shared types and constants for the LLC SAP binding table: request and
// response payloads, action, status and route codes, controller states.
// ---------------------------------------------------------------------------
package lsbt_pkg;

    // Fixed SAP space: one isap or group index per SAP byte >> 1
    localparam int NUM_SAPS  = 128;
    localparam int SAP_IDX_W = 7;

    // SAP and control byte values the checks and the classifier look at
    localparam logic [7:0] SAP_NULL  = 8'h00;
    localparam logic [7:0] SAP_SNAP  = 8'hAA;
    localparam logic [7:0] SAP_MAX   = 8'hFF;
    localparam logic [7:0] CTL_UI    = 8'h03;
    localparam logic [1:0] CTL_U_FMT = 2'b11;

    typedef logic [NUM_SAPS-1:0] t_members;

    typedef enum logic [2:0] {
        ACT_ENA_ISAP  = 3'd0,
        ACT_DIS_ISAP  = 3'd1,
        ACT_ENA_GSAP  = 3'd2,
        ACT_DIS_GSAP  = 3'd3,
        ACT_TEST_GSAP = 3'd4,
        ACT_CLASSIFY  = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_INVALID   = 2'd1,
        STAT_IN_USE    = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RT_DROP   = 2'd0,
        RT_LLC    = 2'd1,
        RT_OWNER  = 2'd2,
        RT_FANOUT = 2'd3
    } t_route;

    // Controller states
    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2,
        S_WALK  = 2'd3
    } t_state;

    typedef struct packed {
        logic [2:0] action;
        logic [1:0] iface;
        logic [7:0] ind_sap;
        logic [7:0] grp_sap;
        logic [7:0] owner_id;
        logic       class_one;
        logic [7:0] dest_sap;
        logic [7:0] ctl_byte;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        bit_set;
        logic [1:0]  route;
        logic [7:0]  owner_out;
        logic [63:0] members_low;
        logic [63:0] members_high;
    } t_rsp;

endpackage

[hdl/lsbt_ram.sv]
// ---------------------------------------------------------------------------
// lsbt_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered output that holds its value while no read is issued.
// ---------------------------------------------------------------------------
module lsbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered output
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/llc_sap_binding_table.sv]
// ---------------------------------------------------------------------------
// llc_sap_binding_table
// Per-interface IEEE 802.2 SAP binding table: isap owner / class-1 binding,
// group SAP membership bitmap and receive DSAP classification.
//
//   channel   direction  handshake                     payload
//   -------   ---------  ----------------------------  -------
//   request   in         i_req_valid / o_req_ready     i_req (t_req)
//   response  out        o_rsp_valid / i_rsp_ready     o_rsp (t_rsp)
//   config    in         i_cfg_we (no wait)            i_cfg_wdata
//
// - Each request is one read-modify-write of the owner RAM and the group
//   RAM: accept + read, then execute and write back.
// - Disable isap adds a walk over all NUM_SAPS group rows of the interface,
//   one row per cycle through the group RAM.
// - After reset a clearing pass zeroes all NUM_IFACES * NUM_SAPS rows of
//   both RAMs, with no request accepted; config writes are taken throughout.
// - A finished response sits in the output register; the next request is
//   accepted while it waits, and execution stalls only if it is still held.
// ---------------------------------------------------------------------------
module llc_sap_binding_table
    import lsbt_pkg::*;
#(
    parameter int NUM_IFACES = 4,
    parameter int OWNER_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  t_req       i_req,
    output logic       o_rsp_valid,
    input  logic       i_rsp_ready,
    output t_rsp       o_rsp,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata
);

    localparam int DEPTH = NUM_IFACES * NUM_SAPS;
    localparam int AW    = $clog2(DEPTH);
    localparam int OWN_W = OWNER_BITS + 1;

    // Row address of (interface, SAP index) in either RAM
    function automatic logic [AW-1:0] row_addr(input logic [1:0]           f,
                                                input logic [SAP_IDX_W-1:0] idx);
        row_addr = AW'((32'(f) << SAP_IDX_W) | 32'(idx));
    endfunction

    t_state               r_state, n_state;
    logic [AW-1:0]        r_clr, n_clr;
    logic [SAP_IDX_W-1:0] r_walk, n_walk;
    logic [2:0]           r_ifaces;
    t_req                 r_req;
    t_rsp                 r_rsp, n_rsp;
    logic                 r_rsp_valid;

    logic                 req_accept;
    logic                 slot_free;
    logic                 rsp_load;

    logic                 own_we, own_re;
    logic [AW-1:0]        own_waddr, own_raddr;
    logic [OWN_W-1:0]     own_wdata, own_rdata;
    logic                 grp_we, grp_re;
    logic [AW-1:0]        grp_waddr, grp_raddr;
    t_members             grp_wdata, grp_rdata;

    logic [OWNER_BITS-1:0] own_q, owner_req;
    logic                 c1_q;
    logic [SAP_IDX_W-1:0] isap_idx;
    t_members             mbit;
    logic                 isap_bad, gsap_bad, iface_ok;
    logic [7:0]           dsap;
    logic [7:0]           ctl;

    // Memories
    lsbt_ram #(.WIDTH(OWN_W), .DEPTH(DEPTH)) u_owner_ram (
        .i_clk  (i_clk),
        .i_we   (own_we),
        .i_waddr(own_waddr),
        .i_wdata(own_wdata),
        .i_re   (own_re),
        .i_raddr(own_raddr),
        .o_rdata(own_rdata)
    );

    lsbt_ram #(.WIDTH(NUM_SAPS), .DEPTH(DEPTH)) u_group_ram (
        .i_clk  (i_clk),
        .i_we   (grp_we),
        .i_waddr(grp_waddr),
        .i_wdata(grp_wdata),
        .i_re   (grp_re),
        .i_raddr(grp_raddr),
        .o_rdata(grp_rdata)
    );

    // Handshake
    assign o_req_ready = (r_state == S_IDLE);
    assign req_accept  = i_req_valid && o_req_ready;
    assign slot_free   = !r_rsp_valid || i_rsp_ready;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Decoded fields of the captured request
    assign own_q     = own_rdata[OWNER_BITS-1:0];
    assign c1_q      = own_rdata[OWNER_BITS];
    assign owner_req = OWNER_BITS'(r_req.owner_id);
    assign isap_idx  = r_req.ind_sap[7:1];
    assign mbit      = t_members'(1) << isap_idx;
    assign isap_bad  = r_req.ind_sap[0] || (r_req.ind_sap == SAP_MAX);
    assign gsap_bad  = (r_req.grp_sap == 8'h00) || !r_req.grp_sap[0];
    assign iface_ok  = ({1'b0, r_req.iface} < r_ifaces) &&
                       (32'(r_req.iface) < NUM_IFACES);
    assign dsap      = r_req.dest_sap;
    assign ctl       = r_req.ctl_byte;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_walk      <= '0;
            r_rsp_valid <= 1'b0;
            r_ifaces    <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_walk  <= n_walk;
            if (rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_ifaces <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_req <= i_req;
        end
        if (rsp_load) begin
            r_rsp <= n_rsp;
        end
    end

    // Next state, memory ports and response
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_walk    = r_walk;
        rsp_load  = 1'b0;
        n_rsp     = '0;
        own_we    = 1'b0;
        own_waddr = row_addr(r_req.iface, isap_idx);
        own_wdata = '0;
        own_re    = 1'b0;
        own_raddr = (i_req.action == ACT_CLASSIFY) ?
                    row_addr(i_req.iface, i_req.dest_sap[7:1]) :
                    row_addr(i_req.iface, i_req.ind_sap[7:1]);
        grp_we    = 1'b0;
        grp_waddr = row_addr(r_req.iface, r_req.grp_sap[7:1]);
        grp_wdata = '0;
        grp_re    = 1'b0;
        grp_raddr = (i_req.action == ACT_CLASSIFY) ?
                    row_addr(i_req.iface, i_req.dest_sap[7:1]) :
                    row_addr(i_req.iface, i_req.grp_sap[7:1]);

        case (r_state)
            // Zero one row of both RAMs per cycle
            S_CLEAR: begin
                own_we    = 1'b1;
                own_waddr = r_clr;
                grp_we    = 1'b1;
                grp_waddr = r_clr;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end

            // Accept a request and read both rows it touches
            S_IDLE: begin
                if (req_accept) begin
                    own_re  = 1'b1;
                    grp_re  = 1'b1;
                    n_state = S_EXEC;
                end
            end

            // Read data is valid: decide, write back, post the response
            S_EXEC: begin
                if (slot_free) begin
                    rsp_load = 1'b1;
                    n_state  = S_IDLE;
                    case (r_req.action)
                        ACT_ENA_ISAP: begin
                            if (isap_bad) begin
                                n_rsp.status = STAT_INVALID;
                            end else if (!iface_ok) begin
                                n_rsp.status = STAT_NOT_FOUND;
                            end else if (own_q != '0) begin
                                n_rsp.status = STAT_IN_USE;
                            end else begin
                                own_we    = 1'b1;
                                own_wdata = {r_req.class_one, owner_req};
                            end
                        end
                        ACT_DIS_ISAP: begin
                            if (isap_bad) begin
                                n_rsp.status = STAT_INVALID;
                            end else if (!iface_ok) begin
                                n_rsp.status = STAT_NOT_FOUND;
                            end else if (own_q == '0 || own_q != owner_req) begin
                                n_rsp.status = STAT_INVALID;
                            end else begin
                                // Unbind, keep class-1 flag, then walk the groups
                                own_we    = 1'b1;
                                own_wdata = {c1_q, {OWNER_BITS{1'b0}}};
                                grp_re    = 1'b1;
                                grp_raddr = row_addr(r_req.iface, '0);
                                n_walk    = '0;
                                n_state   = S_WALK;
                            end
                        end
                        ACT_ENA_GSAP, ACT_DIS_GSAP, ACT_TEST_GSAP: begin
                            if (isap_bad || gsap_bad) begin
                                n_rsp.status = STAT_INVALID;
                            end else if (!iface_ok) begin
                                n_rsp.status = STAT_NOT_FOUND;
                            end else if (r_req.action == ACT_ENA_GSAP) begin
                                grp_we    = 1'b1;
                                grp_wdata = grp_rdata | mbit;
                            end else if (r_req.action == ACT_DIS_GSAP) begin
                                grp_we    = 1'b1;
                                grp_wdata = grp_rdata & ~mbit;
                            end else begin
                                n_rsp.bit_set = |(grp_rdata & mbit);
                            end
                        end
                        ACT_CLASSIFY: begin
                            if (!iface_ok) begin
                                n_rsp.status = STAT_NOT_FOUND;
                            end else if (dsap == SAP_NULL || dsap == SAP_SNAP) begin
                                // Null or SNAP SAP: unnumbered frames only, no UI to null
                                if (ctl[1:0] == CTL_U_FMT &&
                                    !(ctl == CTL_UI && dsap == SAP_NULL)) begin
                                    n_rsp.route = RT_LLC;
                                end
                            end else if (!dsap[0]) begin
                                if (own_q != '0) begin
                                    if (!c1_q) begin
                                        n_rsp.route     = RT_OWNER;
                                        n_rsp.owner_out = 8'(own_q);
                                    end else if (ctl[1:0] == CTL_U_FMT) begin
                                        n_rsp.route     = RT_LLC;
                                        n_rsp.owner_out = 8'(own_q);
                                    end
                                end
                            end else if (grp_rdata != '0) begin
                                n_rsp.route        = RT_FANOUT;
                                n_rsp.members_low  = grp_rdata[63:0];
                                n_rsp.members_high = grp_rdata[127:64];
                            end
                        end
                        default: begin
                            n_rsp.status = STAT_INVALID;
                        end
                    endcase
                end
            end

            // Group walk: write back row r_walk, read the next one
            S_WALK: begin
                grp_we    = 1'b1;
                grp_waddr = row_addr(r_req.iface, r_walk);
                grp_wdata = grp_rdata & ~mbit;
                if (r_walk == SAP_IDX_W'(NUM_SAPS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    grp_re    = 1'b1;
                    grp_raddr = row_addr(r_req.iface, r_walk + 1'b1);
                    n_walk    = r_walk + 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A response is only posted from the execute cycle
    a_rsp_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_valid) |-> $past(r_state) == S_EXEC)
        else $error("response posted outside execute");

    // No request taken while the clearing pass runs
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_req_ready)
        else $error("request accepted during clearing pass");

    // The group walk steps one row per cycle
    a_walk_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_walk != SAP_IDX_W'(NUM_SAPS - 1)) |=>
        (r_state == S_WALK && r_walk == SAP_IDX_W'($past(r_walk) + 1'b1)))
        else $error("group walk skipped or stalled");

    // Group RAM never reads the row it writes in the same cycle
    a_grp_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (grp_we && grp_re) |-> grp_waddr != grp_raddr)
        else $error("group RAM read and write to the same row");

    // Owner RAM is never written while a new request is read
    a_own_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        own_re |-> !own_we)
        else $error("owner RAM read overlaps a write");

endmodule
